### sv/bgle_pkg.sv
// Shared constants, types and the saturating-increment helper of the genotype line encoder.
package bgle_pkg;

  localparam int MAX_LOCI    = 4096;
  localparam int ADDR_W      = $clog2(MAX_LOCI);
  localparam int IDX_W       = 13;
  localparam int CHAR_W      = 8;
  localparam int COUNT_BITS  = 24;
  localparam int KIND_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [IDX_W-1:0] LOCI_RESET    = IDX_W'(4096);
  localparam logic [IDX_W-1:0] MAX_LOCI_IDX  = IDX_W'(MAX_LOCI);
  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(MAX_LOCI - 1);

  localparam logic [KIND_W-1:0] KIND_FIRST    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_END = 3'd2;
  localparam logic [KIND_W-1:0] KIND_THIRD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TOO_MANY = 3'd4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  // One classified byte waiting between the front and the back.
  typedef struct packed {
    logic              nl;
    logic [CHAR_W-1:0] chr;
  } qent_t;

  // One locus entry of the allele memory.
  typedef struct packed {
    logic                  fk;
    logic                  sk;
    logic [CHAR_W-1:0]     fch;
    logic [CHAR_W-1:0]     sch;
    logic [COUNT_BITS-1:0] fc;
    logic [COUNT_BITS-1:0] sc;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [IDX_W-1:0]      locus_index;
    logic                  has_genotype;
    logic                  allele_bit;
    logic [COUNT_BITS-1:0] first_allele_count;
    logic [COUNT_BITS-1:0] second_allele_count;
  } result_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic  valid;
    qent_t head;
  } qstat_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

### sv/bgle_if.sv
// Valid/ready channel interfaces for the character input and the result output.
interface bgle_char_if;
  logic                       valid;
  logic                       ready;
  logic [bgle_pkg::CHAR_W-1:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface bgle_result_if;
  logic                           valid;
  logic                           ready;
  logic [bgle_pkg::KIND_W-1:0]     kind;
  logic [bgle_pkg::IDX_W-1:0]      locus_index;
  logic                           has_genotype;
  logic                           allele_bit;
  logic [bgle_pkg::COUNT_BITS-1:0] first_allele_count;
  logic [bgle_pkg::COUNT_BITS-1:0] second_allele_count;

  modport source (output valid, output kind, output locus_index, output has_genotype,
                  output allele_bit, output first_allele_count,
                  output second_allele_count, input ready);
  modport sink   (input valid, input kind, input locus_index, input has_genotype,
                  input allele_bit, input first_allele_count,
                  input second_allele_count, output ready);
endinterface

### sv/bgle_front.sv
// Front end: accepts bytes, drops whitespace and classifies the rest for the queue.
module bgle_front (
  input  logic                rst_n,
  bgle_char_if.sink           in_chan,
  input  logic                clr_busy,
  input  logic                q_full,
  output logic                push,
  output bgle_pkg::qent_t     push_data
);

  logic is_ws;
  logic accept;

  assign is_ws = (in_chan.char_byte == bgle_pkg::CH_SPACE) ||
                 (in_chan.char_byte == bgle_pkg::CH_TAB) ||
                 (in_chan.char_byte == bgle_pkg::CH_CR);

  // Whitespace is taken from the channel but never reaches the queue.
  assign in_chan.ready = !q_full && !clr_busy && rst_n;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = accept && !is_ws;

  assign push_data.nl  = (in_chan.char_byte == bgle_pkg::CH_NL);
  assign push_data.chr = in_chan.char_byte;

endmodule

### sv/bgle_queue.sv
// Small register queue between the classifying front end and the locus back end.
module bgle_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bgle_pkg::qent_t push_data,
  input  logic            pop,
  output logic            full,
  output bgle_pkg::qstat_t stat
);

  bgle_pkg::qent_t               slot_r [bgle_pkg::QUEUE_DEPTH];
  logic [bgle_pkg::QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [bgle_pkg::QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [bgle_pkg::QPTR_W:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == (bgle_pkg::QPTR_W+1)'(bgle_pkg::QUEUE_DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign stat.head  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + bgle_pkg::QPTR_W'(1) : wptr_r;
    rptr_nxt = pop  ? rptr_r + bgle_pkg::QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (bgle_pkg::QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (bgle_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

### sv/bgle_back.sv
// Back end: locus memory, read-modify-write of allele state and the result register.
module bgle_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bgle_pkg::IDX_W-1:0]    cfg_wdata,
  input  bgle_pkg::qstat_t              q_stat,
  output logic                          q_pop,
  output logic                          clr_busy,
  bgle_result_if.source                 out_chan
);

  bgle_pkg::entry_t               mem_r [bgle_pkg::MAX_LOCI];
  bgle_pkg::entry_t               rd_data_r;
  bgle_pkg::entry_t               byp_data_r;
  logic                           byp_sel_r;
  bgle_pkg::entry_t               cur;

  logic [bgle_pkg::IDX_W-1:0]     loci_r;
  logic [bgle_pkg::IDX_W-1:0]     limit;
  logic                           clr_busy_r;
  logic [bgle_pkg::ADDR_W-1:0]    clr_addr_r;

  logic                           e_vld_r;
  bgle_pkg::qent_t                e_item_r;
  logic                           e_fire;
  logic [bgle_pkg::IDX_W-1:0]     pointer_r, pointer_nxt, ptr_e;
  logic                           phase_r, phase_nxt, phase_e;

  logic                           is_first, is_second, third, not_zero;
  logic                           wr_en;
  bgle_pkg::entry_t               wr_data;
  bgle_pkg::result_t              res;
  bgle_pkg::result_t              out_res_r;
  logic                           out_vld_r;

  logic                           mem_we;
  logic [bgle_pkg::ADDR_W-1:0]    mem_waddr;
  bgle_pkg::entry_t               mem_wdata;
  logic [bgle_pkg::ADDR_W-1:0]    rd_addr;

  // The entry written in the same cycle as the memory read wins over the stale read data.
  assign cur   = byp_sel_r ? byp_data_r : rd_data_r;
  assign limit = (loci_r < bgle_pkg::MAX_LOCI_IDX) ? loci_r : bgle_pkg::MAX_LOCI_IDX;

  assign not_zero  = (e_item_r.chr != bgle_pkg::CH_ZERO);
  assign is_first  = cur.fk && (e_item_r.chr == cur.fch);
  assign is_second = cur.sk && (e_item_r.chr == cur.sch);
  assign third     = cur.fk && cur.sk && !is_first && !is_second;

  always_comb begin
    res             = '0;
    res.locus_index = pointer_r;
    wr_en           = 1'b0;
    wr_data         = cur;
    ptr_e           = pointer_r;
    phase_e         = phase_r;
    if (e_item_r.nl) begin
      res.kind = bgle_pkg::KIND_LINE_END;
      ptr_e    = '0;
      phase_e  = 1'b0;
    end else if (pointer_r >= limit) begin
      res.kind = bgle_pkg::KIND_TOO_MANY;
    end else if (not_zero && third) begin
      res.kind = bgle_pkg::KIND_THIRD;
    end else begin
      if (not_zero) begin
        wr_en = 1'b1;
        if (!cur.fk) begin
          wr_data.fk  = 1'b1;
          wr_data.fch = e_item_r.chr;
          wr_data.fc  = bgle_pkg::sat_inc(cur.fc);
        end else if (is_first) begin
          wr_data.fc  = bgle_pkg::sat_inc(cur.fc);
        end else if (!cur.sk) begin
          wr_data.sk  = 1'b1;
          wr_data.sch = e_item_r.chr;
          wr_data.sc  = bgle_pkg::sat_inc(cur.sc);
          res.allele_bit = 1'b1;
        end else begin
          wr_data.sc  = bgle_pkg::sat_inc(cur.sc);
          res.allele_bit = 1'b1;
        end
      end
      res.kind                = phase_r ? bgle_pkg::KIND_SECOND : bgle_pkg::KIND_FIRST;
      res.has_genotype        = !phase_r && not_zero;
      res.first_allele_count  = wr_data.fc;
      res.second_allele_count = wr_data.sc;
      if (phase_r) begin
        ptr_e   = pointer_r + bgle_pkg::IDX_W'(1);
        phase_e = 1'b0;
      end else begin
        phase_e = 1'b1;
      end
    end
  end

  assign e_fire      = e_vld_r && (!out_vld_r || out_chan.ready);
  assign q_pop       = q_stat.valid && !clr_busy_r && (!e_vld_r || e_fire);
  assign pointer_nxt = e_fire ? ptr_e : pointer_r;
  assign phase_nxt   = e_fire ? phase_e : phase_r;
  // The next item reads the locus that this one leaves the pointer on.
  assign rd_addr     = pointer_nxt[bgle_pkg::ADDR_W-1:0];

  assign mem_we    = clr_busy_r || (e_fire && wr_en);
  assign mem_waddr = clr_busy_r ? clr_addr_r : pointer_r[bgle_pkg::ADDR_W-1:0];
  assign mem_wdata = clr_busy_r ? bgle_pkg::entry_t'('0) : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rd_data_r  <= mem_r[rd_addr];
      byp_data_r <= mem_wdata;
      byp_sel_r  <= mem_we && (mem_waddr == rd_addr);
      e_item_r   <= q_stat.head;
    end
    if (e_fire) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loci_r     <= bgle_pkg::LOCI_RESET;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      e_vld_r    <= 1'b0;
      pointer_r  <= '0;
      phase_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        loci_r <= cfg_wdata;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + bgle_pkg::ADDR_W'(1);
        if (clr_addr_r == bgle_pkg::LAST_ADDR) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (q_pop) begin
        e_vld_r <= 1'b1;
      end else if (e_fire) begin
        e_vld_r <= 1'b0;
      end
      pointer_r <= pointer_nxt;
      phase_r   <= phase_nxt;
      if (e_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign clr_busy                     = clr_busy_r;
  assign out_chan.valid               = out_vld_r;
  assign out_chan.kind                = out_res_r.kind;
  assign out_chan.locus_index         = out_res_r.locus_index;
  assign out_chan.has_genotype        = out_res_r.has_genotype;
  assign out_chan.allele_bit          = out_res_r.allele_bit;
  assign out_chan.first_allele_count  = out_res_r.first_allele_count;
  assign out_chan.second_allele_count = out_res_r.second_allele_count;

endmodule

### sv/biallelic_genotype_line_encoder_top.sv
// Path: a byte that is taken waits in a queue slot, then in the execute register,
// and its result is held in the output register. Throughput: one byte per cycle
// while the output is not stalled, with forwarding of the entry written with the read.
// Reset: synchronous, active low; afterwards a clearing pass writes all 4096 locus
// entries, one per cycle, and no byte is taken until that pass is done.
// Configuration writes are taken whenever reset is not asserted, the clearing pass included.
module biallelic_genotype_line_encoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  bgle_char_if.sink                  in_chan,
  bgle_result_if.source              out_chan,
  input  logic                       cfg_we,
  input  logic [bgle_pkg::IDX_W-1:0] cfg_wdata
);

  logic              push;
  bgle_pkg::qent_t   push_data;
  logic              q_full;
  logic              q_pop;
  logic              clr_busy;
  bgle_pkg::qstat_t  q_stat;

  bgle_front u_front (
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .clr_busy  (clr_busy),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bgle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .stat      (q_stat)
  );

  bgle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_chan  (out_chan)
  );

endmodule

### sv/bgle_checker.sv
// Port-level checks of the genotype line encoder and their binding to the top level.
module bgle_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bgle_pkg::KIND_W-1:0]     kind,
  input logic [bgle_pkg::IDX_W-1:0]      locus_index,
  input logic                            has_genotype,
  input logic                            allele_bit,
  input logic [bgle_pkg::COUNT_BITS-1:0] first_cnt,
  input logic [bgle_pkg::COUNT_BITS-1:0] second_cnt
);

  // A stalled result keeps its kind and locus.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(locus_index))
    else $error("stalled result changed");

  // The clearing pass keeps the input closed right after reset.
  assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open during clearing pass");

  // Line ends and errors carry nothing beyond kind and locus.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == bgle_pkg::KIND_LINE_END || kind == bgle_pkg::KIND_THIRD ||
                  kind == bgle_pkg::KIND_TOO_MANY)
    |-> !has_genotype && !allele_bit && first_cnt == '0 && second_cnt == '0)
    else $error("non-call result carries call fields");

  // A second allele call never reports a genotype flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == bgle_pkg::KIND_SECOND |-> !has_genotype)
    else $error("genotype flag on second allele");

  // The locus index never runs past the maximum number of loci.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> locus_index <= bgle_pkg::MAX_LOCI_IDX)
    else $error("locus index out of range");

endmodule

bind biallelic_genotype_line_encoder_top bgle_checker u_bgle_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .kind         (out_chan.kind),
  .locus_index  (out_chan.locus_index),
  .has_genotype (out_chan.has_genotype),
  .allele_bit   (out_chan.allele_bit),
  .first_cnt    (out_chan.first_allele_count),
  .second_cnt   (out_chan.second_allele_count)
);
